>>> rtl/core/ttq_pkg.sv
// Shared types and constants for the tick-driven timer queue.
`default_nettype none
package ttq_pkg;

   localparam int FuncW    = 2;
   localparam int SlotW    = 4;
   localparam int IntervalW = 32;
   localparam int ClockW   = 64;
   localparam int RateW    = 21;
   localparam int MsW      = 6;
   localparam int FracW    = 10;
   localparam int CsrIdxW  = 2;

   localparam logic [FuncW-1:0] FUNC_TICK     = 2'd0;
   localparam logic [FuncW-1:0] FUNC_ONESHOT  = 2'd1;
   localparam logic [FuncW-1:0] FUNC_PERIODIC = 2'd2;
   localparam logic [FuncW-1:0] FUNC_CANCEL   = 2'd3;

   localparam logic [CsrIdxW-1:0] CSR_TICK_RATE = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_MS_TICK   = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_MS_FRAC   = 2'd2;

   typedef struct packed {
      logic [FuncW-1:0]     func;
      logic [SlotW-1:0]     slot;
      logic [IntervalW-1:0] interval_ms;
   } req_type;

   typedef struct packed {
      logic              fired;
      logic [SlotW-1:0]  fired_slot;
      logic              accepted;
      logic [ClockW-1:0] now_ms;
      logic [ClockW-1:0] ticks_seen;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [RateW-1:0] tick_rate_hz;
      logic [MsW-1:0]   ms_per_tick;
      logic [FracW-1:0] ms_fraction_per_tick;
   } cfg_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } push_type;

   typedef enum logic [3:0] {
      S_IDLE, S_TICK, S_HEAD_RD, S_HEAD_CMP, S_REM, S_WR,
      S_INS_RD, S_INS_CMP, S_PUT, S_EMIT, S_FIN
   } state_type;

endpackage
`default_nettype wire

>>> rtl/core/ttq_unit.sv
// Shared 64-bit adder and magnitude comparator.
`default_nettype none
module ttq_unit
   import ttq_pkg::*;
(
   input  wire logic [ClockW-1:0] a,
   input  wire logic [ClockW-1:0] b,
   output logic      [ClockW-1:0] sum,
   output logic                   gt
);
   assign sum = a + b;
   assign gt  = a > b;
endmodule
`default_nettype wire

>>> rtl/core/ttq_seq.sv
// Sequencer: clock, slot stores, sorted list and the per-item walk.
`default_nettype none
module ttq_seq
   import ttq_pkg::*;
#(
   parameter int NUM_TIMERS = 16
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_go,
   input  wire req_type in_req,
   input  wire cfg_type cfg,
   input  wire logic    acc_clear,
   input  wire logic    can_push,
   output push_type     push,
   output logic         busy
);
   localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CW = $clog2(NUM_TIMERS + 1);

   state_type state_ff, state_in;
   logic [FuncW-1:0]     func_ff, func_in;
   logic [IntervalW-1:0] interval_ff, interval_in;
   logic [SW-1:0]        cur_ff, cur_in;
   logic                 walk_ff, walk_in;
   logic                 acc_ff, acc_in;
   logic [CW-1:0]        i_ff, i_in;
   logic                 found_ff, found_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        fires_ff, fires_in;
   logic [NUM_TIMERS-1:0] done_ff, done_in;
   logic [NUM_TIMERS-1:0] active_ff, active_in;
   logic                 pend_ff, pend_in;
   logic [SW-1:0]        pend_slot_ff, pend_slot_in;
   logic [ClockW-1:0]    key_ff, key_in;
   logic [ClockW-1:0]    clock_ff, clock_in;
   logic [ClockW-1:0]    ticks_ff, ticks_in;
   logic [RateW-1:0]     frac_ff, frac_in;
   logic [SW-1:0]        list_ff [NUM_TIMERS];
   logic [SW-1:0]        list_in [NUM_TIMERS];

   logic [ClockW-1:0]    exp_mem [NUM_TIMERS];
   logic [IntervalW-1:0] per_mem [NUM_TIMERS];
   logic [ClockW-1:0]    exp_rd_ff;
   logic [IntervalW-1:0] per_rd_ff;
   logic [SW-1:0]        rd_addr;
   logic                 we_exp, we_per;
   logic [ClockW-1:0]    exp_wdata;
   logic [IntervalW-1:0] per_wdata;

   logic [ClockW-1:0] ua, ub, usum;
   logic              ugt;

   logic [RateW:0]    frac_sum, frac_next;
   logic              carry;
   logic [ClockW-1:0] step_ms;
   logic [6:0]        slot_ext;
   logic [SW-1:0]     in_idx;
   logic              slot_ok;
   logic [CW-1:0]     im1;
   logic [SW-1:0]     ii, iim1;

   ttq_unit u_unit (.a(ua), .b(ub), .sum(usum), .gt(ugt));

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      frac_sum  = {1'b0, frac_ff} + (RateW+1)'(cfg.ms_fraction_per_tick);
      carry     = frac_sum >= {1'b0, cfg.tick_rate_hz};
      frac_next = carry ? frac_sum - {1'b0, cfg.tick_rate_hz} : frac_sum;
      step_ms   = ClockW'(cfg.ms_per_tick) + ClockW'(carry);
      slot_ext  = 7'(in_req.slot);
      in_idx    = slot_ext[SW-1:0];
      slot_ok   = slot_ext < 7'(NUM_TIMERS);
      im1       = i_ff - CW'(1);
      ii        = i_ff[SW-1:0];
      iim1      = im1[SW-1:0];
   end

   // operand selection for the shared unit
   always_comb begin
      case (state_ff)
         S_TICK: begin
            ua = clock_ff;
            ub = step_ms;
         end
         S_WR: begin
            ua = clock_ff;
            ub = ClockW'(walk_ff ? per_rd_ff : interval_ff);
         end
         S_HEAD_CMP: begin
            ua = exp_rd_ff;
            ub = clock_ff;
         end
         S_INS_CMP: begin
            ua = exp_rd_ff;
            ub = key_ff;
         end
         default: begin
            ua = clock_ff;
            ub = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      interval_in  = interval_ff;
      cur_in       = cur_ff;
      walk_in      = walk_ff;
      acc_in       = acc_ff;
      i_in         = i_ff;
      found_in     = found_ff;
      count_in     = count_ff;
      fires_in     = fires_ff;
      done_in      = done_ff;
      active_in    = active_ff;
      pend_in      = pend_ff;
      pend_slot_in = pend_slot_ff;
      key_in       = key_ff;
      clock_in     = clock_ff;
      ticks_in     = ticks_ff;
      frac_in      = frac_ff;
      list_in      = list_ff;
      rd_addr      = cur_ff;
      we_exp       = 1'b0;
      we_per       = 1'b0;
      exp_wdata    = usum;
      per_wdata    = (func_ff == FUNC_PERIODIC) ? interval_ff : '0;
      push.valid   = 1'b0;
      push.data.fired      = 1'b0;
      push.data.fired_slot = '0;
      push.data.accepted   = 1'b1;
      push.data.now_ms     = clock_ff;
      push.data.ticks_seen = ticks_ff;
      push.data.last       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (in_go) begin
               func_in     = in_req.func;
               interval_in = in_req.interval_ms;
               cur_in      = in_idx;
               walk_in     = (in_req.func == FUNC_TICK);
               acc_in      = 1'b1;
               i_in        = '0;
               found_in    = 1'b0;
               if (in_req.func == FUNC_TICK) begin
                  state_in = S_TICK;
               end else if (!slot_ok || (in_req.func == FUNC_PERIODIC &&
                                         in_req.interval_ms == '0)) begin
                  acc_in   = 1'b0;
                  state_in = S_FIN;
               end else if (in_req.func == FUNC_CANCEL) begin
                  state_in = active_ff[in_idx] ? S_REM : S_FIN;
               end else begin
                  // re-arm of a live slot unlinks it first
                  state_in = active_ff[in_idx] ? S_REM : S_WR;
               end
            end
         end
         S_TICK: begin
            clock_in = usum;
            ticks_in = ticks_ff + ClockW'(1);
            frac_in  = frac_next[RateW-1:0];
            fires_in = '0;
            done_in  = '0;
            pend_in  = 1'b0;
            state_in = S_HEAD_RD;
         end
         S_HEAD_RD: begin
            if (count_ff == '0 || fires_ff == CW'(NUM_TIMERS)) begin
               state_in = S_FIN;
            end else begin
               rd_addr  = list_ff[0];
               cur_in   = list_ff[0];
               state_in = S_HEAD_CMP;
            end
         end
         S_HEAD_CMP: begin
            if (ugt || done_ff[cur_ff]) begin
               state_in = S_FIN;
            end else begin
               done_in[cur_ff] = 1'b1;
               fires_in = fires_ff + CW'(1);
               i_in     = '0;
               found_in = 1'b0;
               state_in = S_REM;
            end
         end
         S_REM: begin
            if (i_ff == count_ff) begin
               if (found_ff) count_in = count_ff - CW'(1);
               active_in[cur_ff] = 1'b0;
               if (walk_ff) begin
                  state_in = (per_rd_ff != '0) ? S_WR : S_EMIT;
               end else begin
                  state_in = (func_ff == FUNC_CANCEL) ? S_FIN : S_WR;
               end
            end else begin
               if (found_ff) list_in[iim1] = list_ff[ii];
               if (list_ff[ii] == cur_ff) found_in = 1'b1;
               i_in = i_ff + CW'(1);
            end
         end
         S_WR: begin
            we_exp   = 1'b1;
            we_per   = !walk_ff;
            key_in   = usum;
            i_in     = count_ff;
            state_in = S_INS_RD;
         end
         S_INS_RD: begin
            if (i_ff == '0) begin
               state_in = S_PUT;
            end else begin
               rd_addr  = list_ff[iim1];
               state_in = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            // equal expiries stay ahead of the new entry
            if (ugt) begin
               list_in[ii] = list_ff[iim1];
               i_in        = im1;
               state_in    = S_INS_RD;
            end else begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            list_in[ii]       = cur_ff;
            count_in          = count_ff + CW'(1);
            active_in[cur_ff] = 1'b1;
            state_in          = walk_ff ? S_EMIT : S_FIN;
         end
         S_EMIT: begin
            // a fired slot is held back until we know whether it is the last
            if (pend_ff) begin
               if (can_push) begin
                  push.valid           = 1'b1;
                  push.data.fired      = 1'b1;
                  push.data.fired_slot = SlotW'(pend_slot_ff);
                  pend_slot_in         = cur_ff;
                  state_in             = S_HEAD_RD;
               end
            end else begin
               pend_in      = 1'b1;
               pend_slot_in = cur_ff;
               state_in     = S_HEAD_RD;
            end
         end
         S_FIN: begin
            if (can_push) begin
               push.valid           = 1'b1;
               push.data.fired      = walk_ff & pend_ff;
               push.data.fired_slot = (walk_ff & pend_ff) ? SlotW'(pend_slot_ff) : '0;
               push.data.accepted   = walk_ff | acc_ff;
               push.data.last       = 1'b1;
               pend_in              = 1'b0;
               state_in             = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (acc_clear) frac_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         active_ff <= '0;
         clock_ff  <= '0;
         ticks_ff  <= '0;
         frac_ff   <= '0;
         pend_ff   <= 1'b0;
         walk_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         active_ff <= active_in;
         clock_ff  <= clock_in;
         ticks_ff  <= ticks_in;
         frac_ff   <= frac_in;
         pend_ff   <= pend_in;
         walk_ff   <= walk_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      interval_ff  <= interval_in;
      cur_ff       <= cur_in;
      acc_ff       <= acc_in;
      i_ff         <= i_in;
      found_ff     <= found_in;
      fires_ff     <= fires_in;
      done_ff      <= done_in;
      pend_slot_ff <= pend_slot_in;
      key_ff       <= key_in;
      list_ff      <= list_in;
   end

   always_ff @(posedge clock) begin
      if (we_exp) exp_mem[cur_ff] <= exp_wdata;
      if (we_per) per_mem[cur_ff] <= per_wdata;
      exp_rd_ff <= exp_mem[rd_addr];
      per_rd_ff <= per_mem[rd_addr];
   end

endmodule
`default_nettype wire

>>> rtl/core/tick_driven_timer_queue.sv
// Top level of the tick-driven timer queue: registers, sequencer, result stage.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall| req_type: func, slot, interval_ms
//  rsp     | out       | rsp_valid/rsp_stall| rsp_type: fired .. last
//  csr     | in        | csr_we             | csr_index, csr_wdata
//
// One transaction at a time; req_stall is high from acceptance until the last
// result is handed to the result register. The removal walk steps one list
// entry a cycle, the insertion walk reads and then compares each entry, and
// the slot-store reads are registered. Synchronous reset clears
// the clock, tick count, active slots and list length. rsp_stall holds the
// result register and the sequencer waits on it.
`default_nettype none
module tick_driven_timer_queue
   import ttq_pkg::*;
#(
   parameter int NUM_TIMERS = 16
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_type                 rsp_data,
   input  wire logic               csr_we,
   input  wire logic [CsrIdxW-1:0] csr_index,
   input  wire logic [RateW-1:0]   csr_wdata
);
   cfg_type  cfg_ff, cfg_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_data_ff, rsp_data_in;
   push_type push;
   logic     busy, can_push, acc_clear;

   assign req_stall = busy;
   assign can_push  = !rsp_valid_ff || !rsp_stall;
   assign acc_clear = csr_we && (csr_index == CSR_TICK_RATE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   ttq_seq #(.NUM_TIMERS(NUM_TIMERS)) u_seq (
      .clock    (clock),
      .reset    (reset),
      .in_go    (req_valid && !busy),
      .in_req   (req_data),
      .cfg      (cfg_ff),
      .acc_clear(acc_clear),
      .can_push (can_push),
      .push     (push),
      .busy     (busy)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TICK_RATE: cfg_in.tick_rate_hz         = csr_wdata;
            CSR_MS_TICK:   cfg_in.ms_per_tick          = csr_wdata[MsW-1:0];
            CSR_MS_FRAC:   cfg_in.ms_fraction_per_tick = csr_wdata[FracW-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (push.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = push.data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_rate_hz         <= RateW'(100);
         cfg_ff.ms_per_tick          <= MsW'(10);
         cfg_ff.ms_fraction_per_tick <= '0;
         rsp_valid_ff                <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

>>> rtl/core/ttq_checker.sv
// Port-level checks for the timer queue, bound to the top level.
`default_nettype none
module ttq_checker
   import ttq_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(req_valid && !req_stall)) |-> req_stall)
      else $error("input taken while a transaction was in progress");

   a_nonlast_fired: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> (rsp_data.fired && rsp_data.accepted))
      else $error("non-final result that reports no expiry");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(rsp_valid && rsp_stall)) |-> rsp_valid)
      else $error("result withdrawn while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(rsp_valid && rsp_stall)) |-> $stable(rsp_data))
      else $error("stalled result changed");
endmodule

bind tick_driven_timer_queue ttq_checker u_ttq_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);
`default_nettype wire
